// ----- src/bb3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 edge-aware box blur
// Field widths, register indexes, stage records and the reciprocal table
// used by the rounding divider.
// ----------------------------------------------------------------------------
package bb3_pkg;

    // Channel and pixel widths.
    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 3 * CHAN_W;

    // Window sum and neighbor count widths (9 * 255 fits in 12 bits).
    localparam int SUM_W    = 12;
    localparam int CNT_W    = 4;

    // Reciprocal multiply for the rounding divide.
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 14;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Configuration port.
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd768;

    // Default frame limits.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Output queue depth (power of two).
    localparam int OUTQ_DEPTH = 4;

    // Which neighbors take part in one result.
    typedef struct packed {
        logic result;
        logic left;
        logic right;
        logic top;
        logic bottom;
        logic frame_end;
    } emit_t;

    // Window sums of one result, red first.
    typedef struct packed {
        logic                       result;
        logic                       frame_end;
        logic [CNT_W-1:0]           count;
        logic [2:0][SUM_W-1:0]      sum;
    } sum_t;

    // One finished output item.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } result_t;

    // Scaled reciprocal of a neighbor count, 2^RECIP_SHIFT / count rounded up.
    function automatic logic [RECIP_W-1:0] count_recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] k;
        unique case (count)
            4'd1:    k = 15'd16384;
            4'd2:    k = 15'd8192;
            4'd3:    k = 15'd5462;
            4'd4:    k = 15'd4096;
            4'd6:    k = 15'd2731;
            4'd9:    k = 15'd1821;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ----- src/box_blur_3x3_edge_aware_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Usage: pixels of a frame arrive on the input channel in raster order
// (in_valid, in_stall, pixel_red/green/blue, flush). Each accepted item that
// completes a neighborhood yields one blurred pixel on the output channel
// (out_valid, out_stall, out_red/green/blue, frame_end). Results trail the
// pixels by one row plus one pixel; after the last pixel of a frame the
// source sends frame_width+1 flush items, and frame_end marks the last
// result. A flush item before the last pixel is taken and dropped.
// Frame size is set on the write port (cfg_wr_en, cfg_index, cfg_data)
// between frames.
// Throughput is one item per cycle while in_stall is low: each row memory
// takes one read and one write per cycle. After its item is accepted, a result
// passes the memory read, then the window sum; the divide feeds the queue.
// When the receiver stalls, results wait in a 4-entry queue and in_stall
// rises once the queue holds 2 items, so no item in flight is lost.
// Reset clears counters, window and queue and sets the frame to 1024x768;
// the row memories need no clearing since every read is masked until written.
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top: 3x3 edge-aware box blur
// Frame counters and stage registers around the line store, window sum,
// rounding dividers and output queue.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top #(
    parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input channel.
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bb3_pkg::CHAN_W-1:0]     pixel_red,
    input  logic [bb3_pkg::CHAN_W-1:0]     pixel_green,
    input  logic [bb3_pkg::CHAN_W-1:0]     pixel_blue,
    input  logic                           flush,
    // Output channel.
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bb3_pkg::CHAN_W-1:0]     out_red,
    output logic [bb3_pkg::CHAN_W-1:0]     out_green,
    output logic [bb3_pkg::CHAN_W-1:0]     out_blue,
    output logic                           frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int WCMP  = (bb3_pkg::CFG_WIDTH_W > WW) ? bb3_pkg::CFG_WIDTH_W : WW;
    localparam int HCMP  = (bb3_pkg::CFG_HEIGHT_W > HW) ? bb3_pkg::CFG_HEIGHT_W : HW;
    localparam int QCW   = $clog2(bb3_pkg::OUTQ_DEPTH + 1);
    localparam int STALL_LEVEL = bb3_pkg::OUTQ_DEPTH - 2;
    localparam int PIXEL_W = bb3_pkg::PIXEL_W;

    // Configuration registers.
    logic [bb3_pkg::CFG_WIDTH_W-1:0]  frame_width_reg;
    logic [bb3_pkg::CFG_HEIGHT_W-1:0] frame_height_reg;

    // Frame counters.
    logic [CW-1:0] column_count_reg;
    logic [CW-1:0] column_count_next;
    logic [RW-1:0] row_count_reg;
    logic [RW-1:0] row_count_next;
    logic [WW-1:0] drain_count_reg;
    logic [WW-1:0] drain_count_next;

    // Clamped frame size and per-item decode.
    logic [WCMP-1:0]    w_cmp;
    logic [HCMP-1:0]    h_cmp;
    logic [WW-1:0]      w_eff;
    logic [RW-1:0]      h_ext;
    logic               accept;
    logic               drain;
    logic               proc;
    logic               last;
    logic [CW-1:0]      col;
    logic [WW-1:0]      col_ext;
    logic [RW-1:0]      row;
    logic [PIXEL_W-1:0] px;
    bb3_pkg::emit_t     emit;

    // Stage after accept: memory read in flight.
    logic               s0_valid_reg;
    logic [CW-1:0]      s0_addr_reg;
    logic [PIXEL_W-1:0] s0_px_reg;
    bb3_pkg::emit_t     s0_emit_reg;

    logic [PIXEL_W-1:0] ls_older;
    logic [PIXEL_W-1:0] ls_newer;
    bb3_pkg::sum_t      sums;
    bb3_pkg::result_t   res;
    bb3_pkg::result_t   head;
    logic [2:0][bb3_pkg::CHAN_W-1:0] means;
    logic               q_not_empty;
    logic [QCW-1:0]     q_count;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bb3_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= bb3_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bb3_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[bb3_pkg::CFG_WIDTH_W-1:0];
                bb3_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[bb3_pkg::CFG_HEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Frame size clamped to the supported range.
    always_comb
    begin
        w_cmp = WCMP'(frame_width_reg);
        if (w_cmp == '0)
        begin
            w_cmp = WCMP'(1);
        end
        else if (w_cmp > WCMP'(MAX_WIDTH))
        begin
            w_cmp = WCMP'(MAX_WIDTH);
        end
        h_cmp = HCMP'(frame_height_reg);
        if (h_cmp == '0)
        begin
            h_cmp = HCMP'(1);
        end
        else if (h_cmp > HCMP'(MAX_HEIGHT))
        begin
            h_cmp = HCMP'(MAX_HEIGHT);
        end
        w_eff = w_cmp[WW-1:0];
        h_ext = RW'(h_cmp[HW-1:0]);
    end

    // Handshake: stall depends on the queue fill alone.
    assign in_stall = (q_count >= QCW'(STALL_LEVEL));
    assign accept   = in_valid && !in_stall;

    // Item decode: position, pixel and which neighbors take part.
    always_comb
    begin
        drain = (row_count_reg >= h_ext);
        proc  = accept && (drain || !flush);
        last  = drain && !(drain_count_reg < w_eff);

        if (!drain)
        begin
            col = column_count_reg;
        end
        else if (!last)
        begin
            col = drain_count_reg[CW-1:0];
        end
        else
        begin
            col = '0;
        end
        col_ext = WW'(col);
        row     = last ? row_count_reg + RW'(1) : row_count_reg;
        px      = drain ? '0 : {pixel_red, pixel_green, pixel_blue};

        // Row start finishes the last pixel two rows back.
        if (col == '0)
        begin
            emit.result    = (row >= RW'(2));
            emit.left      = (w_eff >= WW'(2));
            emit.right     = 1'b0;
            emit.top       = (row >= RW'(3));
            emit.bottom    = (row <= h_ext);
            emit.frame_end = last;
        end
        else
        begin
            emit.result    = (row >= RW'(1));
            emit.left      = (col >= CW'(2));
            emit.right     = (col_ext < w_eff);
            emit.top       = (row >= RW'(2));
            emit.bottom    = (row < h_ext);
            emit.frame_end = 1'b0;
        end
    end

    // Counter update.
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        drain_count_next  = drain_count_reg;
        if (proc)
        begin
            priority if (last)
            begin
                column_count_next = '0;
                row_count_next    = '0;
                drain_count_next  = '0;
            end
            else if (drain)
            begin
                drain_count_next = drain_count_reg + WW'(1);
            end
            else if (col_ext + WW'(1) >= w_eff)
            begin
                column_count_next = '0;
                row_count_next    = row_count_reg + RW'(1);
            end
            else
            begin
                column_count_next = column_count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            drain_count_reg  <= '0;
            s0_valid_reg     <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            drain_count_reg  <= drain_count_next;
            s0_valid_reg     <= proc;
        end
    end

    // Stage payload while the row memories are read.
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            s0_addr_reg <= col;
            s0_px_reg   <= px;
            s0_emit_reg <= emit;
        end
    end

    // Row memories: the middle row moves up, the new pixel becomes the middle.
    bb3_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (CW)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (proc),
        .rd_addr  (col),
        .wr_en    (s0_valid_reg),
        .wr_addr  (s0_addr_reg),
        .wr_older (ls_newer),
        .wr_newer (s0_px_reg),
        .older    (ls_older),
        .newer    (ls_newer)
    );

    // Window shift and masked sums.
    bb3_window_sum u_window_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (s0_valid_reg),
        .emit    (s0_emit_reg),
        .col_top (ls_older),
        .col_mid (ls_newer),
        .col_bot (s0_px_reg),
        .sums    (sums)
    );

    // One rounding divider per channel.
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_div
        bb3_round_div u_round_div (
            .sum   (sums.sum[ch]),
            .count (sums.count),
            .mean  (means[ch])
        );
    end

    always_comb
    begin
        res.red       = means[2];
        res.green     = means[1];
        res.blue      = means[0];
        res.frame_end = sums.frame_end;
    end

    // Output queue.
    bb3_out_queue #(
        .DEPTH (bb3_pkg::OUTQ_DEPTH),
        .PTR_W ($clog2(bb3_pkg::OUTQ_DEPTH)),
        .CNT_W (QCW)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sums.result),
        .push_data (res),
        .pop       (q_not_empty && !out_stall),
        .head      (head),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign out_valid = q_not_empty;
    assign out_red   = head.red;
    assign out_green = head.green;
    assign out_blue  = head.blue;
    assign frame_end = head.frame_end;

`ifndef SYNTH
    // The queue never holds more items than it has entries.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCW'(bb3_pkg::OUTQ_DEPTH))
        else $error("output queue overflow");

    // The last drain item restarts the frame counters.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        proc && last |=> row_count_reg == '0 && drain_count_reg == '0 &&
        column_count_reg == '0)
        else $error("frame counters not cleared after the last drain item");

    // A sum that reaches the dividers has a valid neighbor count.
    a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
        sums.result |-> (sums.count == 4'd4 || sums.count == 4'd6 ||
        sums.count == 4'd9 || sums.count == 4'd1 || sums.count == 4'd2 ||
        sums.count == 4'd3))
        else $error("neighbor count out of range");

    // A processed item always reaches the window stage in the next cycle.
    a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> s0_valid_reg)
        else $error("processed item lost before the window stage");
`endif

endmodule

// ----- src/bb3_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_line_store: the two row memories
// One read and one write per cycle on each memory. A read that hits the
// entry written in the same cycle takes the written data by forwarding.
// ----------------------------------------------------------------------------
module bb3_line_store #(
    parameter int MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [bb3_pkg::PIXEL_W-1:0] wr_older,
    input  logic [bb3_pkg::PIXEL_W-1:0] wr_newer,
    output logic [bb3_pkg::PIXEL_W-1:0] older,
    output logic [bb3_pkg::PIXEL_W-1:0] newer
);

    logic [bb3_pkg::PIXEL_W-1:0] older_mem [MAX_WIDTH];
    logic [bb3_pkg::PIXEL_W-1:0] newer_mem [MAX_WIDTH];

    logic [bb3_pkg::PIXEL_W-1:0] older_rd_reg;
    logic [bb3_pkg::PIXEL_W-1:0] newer_rd_reg;
    logic [bb3_pkg::PIXEL_W-1:0] fwd_older_reg;
    logic [bb3_pkg::PIXEL_W-1:0] fwd_newer_reg;
    logic                        fwd_reg;

    // Memory write and registered read; the read sees the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
        if (rd_en)
        begin
            older_rd_reg  <= older_mem[rd_addr];
            newer_rd_reg  <= newer_mem[rd_addr];
            fwd_older_reg <= wr_older;
            fwd_newer_reg <= wr_newer;
        end
    end

    // Remember whether the read collided with the write of the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Forwarded data wins over the stale memory read.
    assign older = fwd_reg ? fwd_older_reg : older_rd_reg;
    assign newer = fwd_reg ? fwd_newer_reg : newer_rd_reg;

endmodule

// ----- src/bb3_window_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_window_sum: 3x3 window and masked neighborhood sums
// Shifts the window by one column per item and adds up, per channel, the
// neighbors that lie inside the frame. The sums are registered.
// ----------------------------------------------------------------------------
module bb3_window_sum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  bb3_pkg::emit_t              emit,
    input  logic [bb3_pkg::PIXEL_W-1:0] col_top,
    input  logic [bb3_pkg::PIXEL_W-1:0] col_mid,
    input  logic [bb3_pkg::PIXEL_W-1:0] col_bot,
    output bb3_pkg::sum_t               sums
);

    localparam int CNT_W  = bb3_pkg::CNT_W;
    localparam int SUM_W  = bb3_pkg::SUM_W;
    localparam int CHAN_W = bb3_pkg::CHAN_W;
    localparam int PIXEL_W = bb3_pkg::PIXEL_W;

    // Older two columns of the window, top row first.
    logic [PIXEL_W-1:0] win0_reg [3];
    logic [PIXEL_W-1:0] win1_reg [3];

    logic [PIXEL_W-1:0] pix [3][3];
    logic [2:0]         row_en;
    logic [2:0]         col_en;
    logic [CNT_W-1:0]   rows_n;
    logic [CNT_W-1:0]   cols_n;
    logic [2*CNT_W-1:0] cnt_prod;
    bb3_pkg::sum_t      sums_next;
    bb3_pkg::sum_t      sums_reg;

    // Window after the shift: the new column enters on the right.
    always_comb
    begin
        for (int row = 0; row < 3; row++)
        begin
            pix[row][0] = win0_reg[row];
            pix[row][1] = win1_reg[row];
        end
        pix[0][2] = col_top;
        pix[1][2] = col_mid;
        pix[2][2] = col_bot;
    end

    // Masked per-channel sums and the neighbor count.
    always_comb
    begin
        row_en   = {emit.bottom, 1'b1, emit.top};
        col_en   = {emit.right, 1'b1, emit.left};
        rows_n   = CNT_W'(1) + CNT_W'(emit.top) + CNT_W'(emit.bottom);
        cols_n   = CNT_W'(1) + CNT_W'(emit.left) + CNT_W'(emit.right);
        cnt_prod = rows_n * cols_n;

        sums_next           = '0;
        sums_next.result    = valid && emit.result;
        sums_next.frame_end = emit.frame_end;
        sums_next.count     = cnt_prod[CNT_W-1:0];
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int row = 0; row < 3; row++)
            begin
                for (int col = 0; col < 3; col++)
                begin
                    if (row_en[row] && col_en[col])
                    begin
                        sums_next.sum[2-ch] = sums_next.sum[2-ch]
                            + SUM_W'(pix[row][col][PIXEL_W-1-CHAN_W*ch -: CHAN_W]);
                    end
                end
            end
        end
    end

    // Window shift on every processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int row = 0; row < 3; row++)
            begin
                win0_reg[row] <= '0;
                win1_reg[row] <= '0;
            end
        end
        else if (valid)
        begin
            for (int row = 0; row < 3; row++)
            begin
                win0_reg[row] <= pix[row][1];
                win1_reg[row] <= pix[row][2];
            end
        end
    end

    // Sum register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
        end
        else
        begin
            sums_reg <= sums_next;
        end
    end

    assign sums = sums_reg;

endmodule

// ----- src/bb3_round_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_round_div: rounded mean of one channel
// Computes (2*sum + count) / (2*count) as (sum + count/2) / count, with the
// divide done by a multiply with a scaled reciprocal of the count.
// ----------------------------------------------------------------------------
module bb3_round_div (
    input  logic [bb3_pkg::SUM_W-1:0]  sum,
    input  logic [bb3_pkg::CNT_W-1:0]  count,
    output logic [bb3_pkg::CHAN_W-1:0] mean
);

    localparam int SUM_W  = bb3_pkg::SUM_W;
    localparam int PROD_W = bb3_pkg::PROD_W;

    logic [SUM_W-1:0]  biased;
    logic [PROD_W-1:0] prod;

    // Half the count added first gives round half up.
    always_comb
    begin
        biased = sum + SUM_W'(count >> 1);
        prod   = PROD_W'(biased) * PROD_W'(bb3_pkg::count_recip(count));
        mean   = prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
    end

endmodule

// ----- src/bb3_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_out_queue: output item queue
// Small register queue that holds finished items while the receiver stalls.
// The head entry drives the output ports directly.
// ----------------------------------------------------------------------------
module bb3_out_queue #(
    parameter int DEPTH = bb3_pkg::OUTQ_DEPTH,
    parameter int PTR_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bb3_pkg::result_t  push_data,
    input  logic              pop,
    output bb3_pkg::result_t  head,
    output logic              not_empty,
    output logic [CNT_W-1:0]  count
);

    bb3_pkg::result_t entry_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = entry_mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule
